[hw/rtl/soarsc_pkg.sv]
// ----------------------------------------------------------------------------
// soarsc_pkg
// shared types, widths and the score sequence table for the spill selector
// ----------------------------------------------------------------------------
package soarsc_pkg;

    localparam int NUM_CLUSTERS = 256;
    localparam int DIM          = 128;
    localparam int VALUE_BITS   = 16;

    localparam int CL_W   = 8;
    localparam int EL_W   = 7;
    localparam int CADR_W = CL_W + EL_W;
    localparam int SD_W   = 40;
    localparam int PJ_W   = 41;
    localparam int B1_W   = 57;
    localparam int SC_W   = 98;
    localparam int DIG_W  = 21;
    localparam int LAM_W  = 16;
    localparam int CNT_W  = 9;

    localparam logic [1:0] REG_LAMBDA   = 2'd0;
    localparam logic [1:0] REG_CLUSTERS = 2'd1;

    localparam logic [3:0] LAST_STEP = 4'd11;
    localparam logic [3:0] CMP_STEP  = 4'd13;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PRIM  = 7'b0000010,
        ST_SWEEP = 7'b0000100,
        ST_DRAIN = 7'b0001000,
        ST_SCRD  = 7'b0010000,
        ST_SCLAT = 7'b0100000,
        ST_SCMAC = 7'b1000000
    } t_state;

    typedef enum logic [1:0] {
        SRC_MAG = 2'd0,
        SRC_SD  = 2'd1,
        SRC_B1  = 2'd2,
        SRC_LAM = 2'd3
    } t_src;

    // multiplier source N1 shares the SD code on the b side
    typedef struct packed {
        t_src       a_src;
        logic [1:0] a_dig;
        t_src       b_src;
        logic [1:0] b_dig;
        logic [6:0] shift;
        logic       to_b1;
    } t_step;

    // score = (sd*n1 << 8) + (mag*lambda)*mag, in 21-bit digits
    function automatic t_step step_of(input logic [3:0] s);
        t_step t;
        t = '{SRC_MAG, 2'd0, SRC_LAM, 2'd0, 7'd0, 1'b0};
        case (s)
            4'd0:  t = '{SRC_MAG, 2'd0, SRC_LAM, 2'd0, 7'd0,  1'b1};
            4'd1:  t = '{SRC_MAG, 2'd1, SRC_LAM, 2'd0, 7'd21, 1'b1};
            4'd2:  t = '{SRC_SD,  2'd0, SRC_SD,  2'd0, 7'd8,  1'b0};
            4'd3:  t = '{SRC_SD,  2'd0, SRC_SD,  2'd1, 7'd29, 1'b0};
            4'd4:  t = '{SRC_SD,  2'd1, SRC_SD,  2'd0, 7'd29, 1'b0};
            4'd5:  t = '{SRC_SD,  2'd1, SRC_SD,  2'd1, 7'd50, 1'b0};
            4'd6:  t = '{SRC_B1,  2'd0, SRC_MAG, 2'd0, 7'd0,  1'b0};
            4'd7:  t = '{SRC_B1,  2'd0, SRC_MAG, 2'd1, 7'd21, 1'b0};
            4'd8:  t = '{SRC_B1,  2'd1, SRC_MAG, 2'd0, 7'd21, 1'b0};
            4'd9:  t = '{SRC_B1,  2'd1, SRC_MAG, 2'd1, 7'd42, 1'b0};
            4'd10: t = '{SRC_B1,  2'd2, SRC_MAG, 2'd0, 7'd42, 1'b0};
            4'd11: t = '{SRC_B1,  2'd2, SRC_MAG, 2'd1, 7'd63, 1'b0};
            default: t = '{SRC_MAG, 2'd0, SRC_LAM, 2'd0, 7'd0, 1'b0};
        endcase
        return t;
    endfunction

    function automatic logic [DIG_W-1:0] digit(input logic [3*DIG_W-1:0] v,
                                               input logic [1:0] k);
        logic [DIG_W-1:0] d;
        case (k)
            2'd0:    d = v[DIG_W-1:0];
            2'd1:    d = v[2*DIG_W-1:DIG_W];
            2'd2:    d = v[3*DIG_W-1:2*DIG_W];
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

[hw/rtl/soar_spill_centroid_select.sv]
// ----------------------------------------------------------------------------
// soar_spill_centroid_select
// picks the spill cluster of a document by the soar-adjusted distance
// ----------------------------------------------------------------------------
// usage: a transaction is taken when start is high and busy is low.
// op 0 writes one centroid element into the centroid memory; busy stays
// low. op 1 is one document element tagged with its primary cluster;
// element 0 opens a document and clears all sums. for a document element,
// with n = active cluster count (0 treated as 1, capped at 256), the
// primary centroid is read first, then one shared subtract/square/project
// unit walks the n clusters one per cycle over the centroid and accumulator
// memories, then the pipe drains. on the last element a scoring pass
// follows, cluster by cluster on one 21x21 multiplier, then one result
// transaction on o_result_strobe for a single cycle. with a zero residual
// norm the result (cluster 0, degenerate set) comes straight after the drain.
// the receiver cannot stall; each result is shown exactly once.
// config writes (i_cfg_wr) land at once; the user must make them only
// while idle, the block itself does not enforce it. reset clears control
// state and accumulator valid bits and sets both config registers to 256;
// centroid contents are undefined until loaded. no clearing pass is needed.
// ----------------------------------------------------------------------------
module soar_spill_centroid_select
    import soarsc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_op,
    input  logic [CL_W-1:0]         i_cluster_index,
    input  logic [EL_W-1:0]         i_element_index,
    input  logic signed [15:0]      i_sample_value,
    input  logic                    i_last_element,
    input  logic                    i_cfg_wr,
    input  logic [1:0]              i_cfg_idx,
    input  logic [15:0]             i_cfg_data,
    output logic                    o_result_strobe,
    output logic [CL_W-1:0]         o_spill_cluster,
    output logic                    o_degenerate
);

    // memories
    logic [15:0]     cent_mem [0:NUM_CLUSTERS*DIM-1];
    logic [SD_W-1:0] sd_mem   [0:NUM_CLUSTERS-1];
    logic [PJ_W-1:0] pj_mem   [0:NUM_CLUSTERS-1];
    logic [NUM_CLUSTERS-1:0] r_vld;

    t_state r_state, n_state;

    logic [LAM_W-1:0] r_lambda;
    logic [CNT_W-1:0] r_clusters;

    // latched transaction
    logic [15:0]     r_x;
    logic [EL_W-1:0] r_el;
    logic            r_last;
    logic [CL_W-1:0] r_jlast;
    logic [CL_W-1:0] r_j;

    logic [16:0]     r_res;
    logic [SD_W-1:0] r_n1;

    // memory read data
    logic [15:0]     r_cent_q;
    logic [SD_W-1:0] r_sd_q;
    logic [PJ_W-1:0] r_pj_q;
    logic            r_vld_q;

    // sweep pipe
    logic            r_s1_vld;
    logic [CL_W-1:0] r_s1_j;
    logic            r_s2_vld;
    logic [CL_W-1:0] r_s2_j;
    logic [31:0]     r_dd;
    logic signed [33:0] r_rd;
    logic [SD_W-1:0] r_sd_old;
    logic [PJ_W-1:0] r_pj_old;

    // score unit
    logic [3:0]      r_step;
    logic [SD_W-1:0] r_opsd;
    logic [PJ_W-1:0] r_mag;
    logic [B1_W-1:0] r_b1;
    logic [SC_W-1:0] r_score;
    logic [SC_W-1:0] r_best_score;
    logic [CL_W-1:0] r_best;
    logic [41:0]     r_pp;
    logic [6:0]      r_pp_sh;
    logic            r_pp_b1;
    logic            r_pp_vld;

    logic            r_strobe;
    logic [CL_W-1:0] r_spill;
    logic            r_degen;

    logic accept;
    logic [CNT_W-1:0] act_cnt;
    logic cent_we;
    logic [CADR_W-1:0] cent_ra;
    logic [CL_W-1:0] acc_ra;
    logic acc_we;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // active cluster count clamp
    always_comb begin
        act_cnt = r_clusters;
        if (r_clusters == '0) begin
            act_cnt = CNT_W'(1);
        end else if (r_clusters > CNT_W'(NUM_CLUSTERS)) begin
            act_cnt = CNT_W'(NUM_CLUSTERS);
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda   <= LAM_W'(256);
            r_clusters <= CNT_W'(256);
        end else if (i_cfg_wr) begin
            case (i_cfg_idx)
                REG_LAMBDA:   r_lambda   <= i_cfg_data;
                REG_CLUSTERS: r_clusters <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // centroid memory
    assign cent_we = accept && !i_op;
    assign cent_ra = (r_state == ST_SWEEP) ? {r_j, r_el}
                                           : {i_cluster_index, i_element_index};

    always_ff @(posedge i_clk) begin
        if (cent_we) begin
            cent_mem[{i_cluster_index, i_element_index}] <= i_sample_value;
        end
        r_cent_q <= cent_mem[cent_ra];
    end

    // accumulator memories
    assign acc_ra = r_j;
    assign acc_we = r_s2_vld;

    logic [SD_W:0]   sd_sum;
    logic [SD_W-1:0] sd_new;
    logic [PJ_W:0]   pj_sum;
    logic [PJ_W-1:0] pj_new;

    always_comb begin
        sd_sum = {1'b0, r_sd_old} + (SD_W+1)'(r_dd);
        sd_new = sd_sum[SD_W] ? '1 : sd_sum[SD_W-1:0];
        pj_sum = {r_pj_old[PJ_W-1], r_pj_old} + (PJ_W+1)'(r_rd);
        if (pj_sum[PJ_W] != pj_sum[PJ_W-1]) begin
            pj_new = pj_sum[PJ_W] ? {1'b1, {(PJ_W-1){1'b0}}} : {1'b0, {(PJ_W-1){1'b1}}};
        end else begin
            pj_new = pj_sum[PJ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            sd_mem[r_s2_j] <= sd_new;
            pj_mem[r_s2_j] <= pj_new;
        end
        r_sd_q <= sd_mem[acc_ra];
        r_pj_q <= pj_mem[acc_ra];
    end

    // sweep datapath
    logic signed [16:0] d_val;
    logic signed [16:0] r_prim;
    logic [33:0]        rr_sq;
    logic [SD_W:0]      n1_sum;

    assign d_val  = $signed({r_x[15], r_x}) - $signed({r_cent_q[15], r_cent_q});
    assign r_prim = d_val;
    assign rr_sq  = 34'($signed(r_prim) * $signed(r_prim));
    assign n1_sum = {1'b0, r_n1} + (SD_W+1)'(rr_sq[31:0]);

    // score datapath
    t_step cur;
    logic [3*DIG_W-1:0] a_word;
    logic [3*DIG_W-1:0] b_word;
    logic [DIG_W-1:0]   a_dig;
    logic [DIG_W-1:0]   b_dig;
    logic [PJ_W-1:0]    pj_abs;
    logic [SD_W-1:0]    sd_eff;

    assign cur    = step_of(r_step);
    assign sd_eff = r_vld_q ? r_sd_q : '0;
    assign pj_abs = !r_vld_q ? '0 : (r_pj_q[PJ_W-1] ? (~r_pj_q + PJ_W'(1)) : r_pj_q);

    always_comb begin
        case (cur.a_src)
            SRC_MAG: a_word = (3*DIG_W)'(r_mag);
            SRC_SD:  a_word = (3*DIG_W)'(r_opsd);
            SRC_B1:  a_word = (3*DIG_W)'(r_b1);
            default: a_word = '0;
        endcase
        case (cur.b_src)
            SRC_MAG: b_word = (3*DIG_W)'(r_mag);
            SRC_SD:  b_word = (3*DIG_W)'(r_n1);
            SRC_LAM: b_word = (3*DIG_W)'(r_lambda);
            default: b_word = '0;
        endcase
        a_dig = digit(a_word, cur.a_dig);
        b_dig = digit(b_word, cur.b_dig);
    end

    // control
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_op) n_state = ST_PRIM;
            end
            ST_PRIM:  n_state = ST_SWEEP;
            ST_SWEEP: begin
                if (r_j == r_jlast) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!r_s1_vld && !r_s2_vld) begin
                    if (!r_last || r_n1 == '0) n_state = ST_IDLE;
                    else                        n_state = ST_SCRD;
                end
            end
            ST_SCRD:  n_state = ST_SCLAT;
            ST_SCLAT: n_state = ST_SCMAC;
            ST_SCMAC: begin
                if (r_step == CMP_STEP) begin
                    n_state = (r_j == r_jlast) ? ST_IDLE : ST_SCRD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    logic score_lt;
    assign score_lt = (r_score < r_best_score);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_vld    <= '0;
            r_n1     <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_pp_vld <= 1'b0;
            r_strobe <= 1'b0;
            r_j      <= '0;
            r_step   <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            r_s1_vld <= (r_state == ST_SWEEP);
            r_s2_vld <= r_s1_vld;
            r_pp_vld <= (r_state == ST_SCMAC) && (r_step <= LAST_STEP);

            if (acc_we) r_vld[r_s2_j] <= 1'b1;

            case (r_state)
                ST_IDLE: begin
                    if (accept && i_op) begin
                        r_x     <= i_sample_value;
                        r_el    <= i_element_index;
                        r_last  <= i_last_element;
                        r_jlast <= CL_W'(act_cnt - CNT_W'(1));
                        if (i_element_index == '0) begin
                            r_vld <= '0;
                            r_n1  <= '0;
                        end
                    end
                end
                ST_PRIM: begin
                    r_res <= r_prim;
                    r_n1  <= n1_sum[SD_W] ? '1 : n1_sum[SD_W-1:0];
                    r_j   <= '0;
                end
                ST_SWEEP: begin
                    if (r_j != r_jlast) r_j <= r_j + CL_W'(1);
                end
                ST_DRAIN: begin
                    r_j <= '0;
                    if (!r_s1_vld && !r_s2_vld && r_last && r_n1 == '0) begin
                        r_strobe <= 1'b1;
                        r_spill  <= '0;
                        r_degen  <= 1'b1;
                        r_vld    <= '0;
                        r_n1     <= '0;
                    end
                end
                ST_SCLAT: begin
                    r_opsd  <= sd_eff;
                    r_mag   <= pj_abs;
                    r_b1    <= '0;
                    r_score <= '0;
                    r_step  <= '0;
                end
                ST_SCMAC: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == CMP_STEP) begin
                        if (r_j == '0 || score_lt) begin
                            r_best       <= r_j;
                            r_best_score <= r_score;
                        end
                        if (r_j == r_jlast) begin
                            r_strobe <= 1'b1;
                            r_spill  <= (r_j == '0 || score_lt) ? r_j : r_best;
                            r_degen  <= 1'b0;
                            r_vld    <= '0;
                            r_n1     <= '0;
                        end else begin
                            r_j <= r_j + CL_W'(1);
                        end
                    end
                end
                default: ;
            endcase

            if (r_pp_vld) begin
                if (r_pp_b1) r_b1 <= r_b1 + B1_W'(r_pp << r_pp_sh);
                else         r_score <= r_score + (SC_W'(r_pp) << r_pp_sh);
            end
        end
    end

    // payload pipe registers
    always_ff @(posedge i_clk) begin
        r_vld_q  <= r_vld[acc_ra];
        r_s1_j   <= r_j;
        r_s2_j   <= r_s1_j;
        r_dd     <= 32'($signed(d_val) * $signed(d_val));
        r_rd     <= $signed(r_res) * $signed(d_val);
        r_sd_old <= sd_eff;
        r_pj_old <= r_vld_q ? r_pj_q : '0;
        r_pp     <= a_dig * b_dig;
        r_pp_sh  <= cur.shift;
        r_pp_b1  <= cur.to_b1;
    end

    assign o_result_strobe = r_strobe;
    assign o_spill_cluster = r_spill;
    assign o_degenerate    = r_degen;

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_degenerate |-> o_spill_cluster == '0)
        else $error("degenerate result with non-zero cluster");

    a_pipe_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (r_state == ST_SWEEP || r_state == ST_DRAIN))
        else $error("sweep pipe active outside sweep");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !busy)
        else $error("result while still busy");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCMAC |-> r_step <= CMP_STEP)
        else $error("score step out of range");
`endif

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the soar spill cluster selector: centroids are
// loaded, documents are streamed against a local predictor of the selection,
// and every result strobe is checked field by field in order
// ----------------------------------------------------------------------------

// keeps its own copy of the centroid memory, the sums and the registers, and
// queues the spill choice expected for every closing document element
class spill_tracker;
    typedef struct {
        logic [soarsc_pkg::CL_W-1:0] cluster;
        logic                        degen;
    } t_pick;

    logic signed [15:0]                   cent [soarsc_pkg::NUM_CLUSTERS*soarsc_pkg::DIM];
    logic [soarsc_pkg::SD_W-1:0]          sd_acc [soarsc_pkg::NUM_CLUSTERS];
    logic signed [soarsc_pkg::PJ_W-1:0]   pj_acc [soarsc_pkg::NUM_CLUSTERS];
    logic [soarsc_pkg::SD_W-1:0]          n1_acc;
    logic [soarsc_pkg::LAM_W-1:0]         lambda;
    logic [soarsc_pkg::CNT_W-1:0]         active;
    t_pick                                picks [$];
    int                                   fails;

    function new();
        foreach (cent[i]) cent[i] = '0;
        lambda = 16'd256;
        active = 9'd256;
        fails  = 0;
        clear_sums();
    endfunction

    function void clear_sums();
        foreach (sd_acc[j]) begin
            sd_acc[j] = '0;
            pj_acc[j] = '0;
        end
        n1_acc = '0;
    endfunction

    function int live_count();
        if (active == 0) return 1;
        if (active > soarsc_pkg::NUM_CLUSTERS) return soarsc_pkg::NUM_CLUSTERS;
        return active;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
        if (idx == soarsc_pkg::REG_LAMBDA) lambda = data;
        else if (idx == soarsc_pkg::REG_CLUSTERS) active = data[soarsc_pkg::CNT_W-1:0];
    endfunction

    function void accept(logic op, logic [7:0] cl, logic [6:0] el,
                         logic signed [15:0] x, logic last);
        longint sd_max, pj_max, r, d, s, p;
        int n, best;
        logic [127:0] a, b, m, score, best_score;
        t_pick pk;
        sd_max = (longint'(1) << 40) - 1;
        pj_max = (longint'(1) << 40) - 1;
        if (op == 1'b0) begin
            cent[cl*soarsc_pkg::DIM + el] = x;
            return;
        end
        if (el == 0) clear_sums();
        n = live_count();
        r = longint'(x) - longint'(cent[cl*soarsc_pkg::DIM + el]);
        s = longint'(n1_acc) + r*r;
        n1_acc = (s > sd_max) ? sd_max[39:0] : s[39:0];
        for (int j = 0; j < n; j++) begin
            d = longint'(x) - longint'(cent[j*soarsc_pkg::DIM + el]);
            s = longint'(sd_acc[j]) + d*d;
            sd_acc[j] = (s > sd_max) ? sd_max[39:0] : s[39:0];
            s = longint'(pj_acc[j]) + r*d;
            if (s > pj_max) s = pj_max;
            if (s < -pj_max - 1) s = -pj_max - 1;
            pj_acc[j] = s[40:0];
        end
        if (!last) return;
        if (n1_acc == 0) begin
            pk.cluster = '0;
            pk.degen   = 1'b1;
        end else begin
            best = 0;
            best_score = '0;
            for (int j = 0; j < n; j++) begin
                p = longint'(pj_acc[j]);
                m = (p < 0) ? -p : p;
                a = 128'(sd_acc[j]) * 128'(n1_acc);
                a = a << 8;
                b = m * m;
                b = b * 128'(lambda);
                score = a + b;
                if (j == 0 || score < best_score) begin
                    best = j;
                    best_score = score;
                end
            end
            pk.cluster = best[7:0];
            pk.degen   = 1'b0;
        end
        picks = {picks, pk};
        clear_sums();
    endfunction

    function void compare(logic [7:0] cl, logic degen);
        t_pick pk;
        if (picks.size() == 0) begin
            $display("%0t: result with nothing expected, spill_cluster %0d degenerate %0d",
                     $time, cl, degen);
            fails++;
            return;
        end
        pk = picks.pop_front();
        if (cl !== pk.cluster) begin
            $display("%0t: spill_cluster expected %0d actual %0d", $time, pk.cluster, cl);
            fails++;
        end
        if (degen !== pk.degen) begin
            $display("%0t: degenerate expected %0d actual %0d", $time, pk.degen, degen);
            fails++;
        end
    endfunction

    function int pending();
        return picks.size();
    endfunction
endclass

module tb
    import soarsc_pkg::*;
();

    // register indexes with no register behind them
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;
    localparam logic       OP_LOAD     = 1'b0;
    localparam logic       OP_DOC      = 1'b1;
    localparam int         ITEM_TARGET = 1350;
    localparam int         QUIET_FROM  = 1150;
    localparam int         SETTLE      = 8;
    localparam int         WIDE_COUNT  = 16;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_op = 1'b0;
    logic [CL_W-1:0]    i_cluster_index = '0;
    logic [EL_W-1:0]    i_element_index = '0;
    logic signed [15:0] i_sample_value = '0;
    logic               i_last_element = 1'b0;
    logic               i_cfg_wr = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               o_result_strobe;
    logic [CL_W-1:0]    o_spill_cluster;
    logic               o_degenerate;

    spill_tracker tracker = new();
    bit   loaded [NUM_CLUSTERS][DIM];
    int   items_sent = 0;
    bit   gaps_on = 1'b1;

    soar_spill_centroid_select DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // results cannot be held off: every strobe is checked at the edge ending it
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) tracker.compare(o_spill_cluster, o_degenerate);
    end

    // sample values lean towards the extremes and towards small magnitudes
    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom_range(64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // one transaction, then maybe a burst of idle cycles on the request side
    task automatic put(logic op, logic [7:0] cl, logic [6:0] el, logic [15:0] x,
                       logic last);
        i_op            <= op;
        i_cluster_index <= cl;
        i_element_index <= el;
        i_sample_value  <= x;
        i_last_element  <= last;
        start           <= 1'b1;
        do @(posedge i_clk); while (busy);
        tracker.accept(op, cl, el, x, last);
        if (op == OP_LOAD) loaded[cl][el] = 1'b1;
        items_sent++;
        if (gaps_on && $urandom_range(3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // fill in any centroid element that a document element would read
    task automatic load_needed(logic [7:0] cl, logic [6:0] el);
        int n;
        n = tracker.live_count();
        for (int j = 0; j < n; j++)
            if (!loaded[j][el]) put(OP_LOAD, 8'(j), el, pick_value(), 1'b0);
        if (!loaded[cl][el]) put(OP_LOAD, cl, el, pick_value(), 1'b0);
    endtask

    // mode 0 random, 1 equal to the primary centroid, 2 close to it, 3 extremes
    task automatic document(logic [7:0] cl, int len, int mode);
        logic [15:0] x;
        logic [15:0] c;
        for (int e = 0; e < len; e++) load_needed(cl, 7'(e));
        for (int e = 0; e < len; e++) begin
            c = tracker.cent[cl*DIM + e];
            case (mode)
                1:       x = c;
                2:       x = c + 16'($urandom_range(6)) - 16'd3;
                3:       x = e[0] ? 16'h7fff : 16'h8000;
                default: x = pick_value();
            endcase
            put(OP_DOC, cl, 7'(e), x, e == len - 1);
        end
    endtask

    // quiet point: nothing owed and the block has finished its current item
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        settle();
        i_cfg_wr   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
        i_cfg_wr   <= 1'b0;
    endtask

    initial begin
        int docs;
        int wait_cycles;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero count treated as one, zero weight, extreme samples
        write_reg(REG_CLUSTERS, 16'd0);
        write_reg(REG_LAMBDA, 16'd0);
        document(8'd5, 2, 3);
        // full weight, document equal to its primary centroid, then a near miss
        write_reg(REG_LAMBDA, 16'hffff);
        write_reg(REG_CLUSTERS, 16'd4);
        document(8'd2, 3, 1);
        document(8'd0, 2, 2);
        // writes to spare indexes must leave both registers alone
        write_reg(REG_SPARE_A, 16'd3);
        write_reg(REG_SPARE_B, 16'd0);
        document(8'd3, 2, 0);
        // count raised between two elements of one document: partial sums
        write_reg(REG_CLUSTERS, 16'd2);
        load_needed(8'd1, 7'd0);
        put(OP_DOC, 8'd1, 7'd0, pick_value(), 1'b0);
        write_reg(REG_CLUSTERS, 16'd6);
        load_needed(8'd1, 7'd1);
        put(OP_DOC, 8'd1, 7'd1, pick_value(), 1'b1);
        // count above the cluster total is capped; top element and top cluster
        write_reg(REG_CLUSTERS, 16'hfdff);
        write_reg(REG_LAMBDA, 16'd256);
        load_needed(8'd255, 7'd127);
        put(OP_DOC, 8'd255, 7'd127, pick_value(), 1'b1);

        // random documents with occasional register changes and stray items
        docs = 0;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent > QUIET_FROM) gaps_on = 1'b0;
            if (docs % 16 == 0) begin
                case ($urandom_range(3))
                    0:       write_reg(REG_LAMBDA, 16'd0);
                    1:       write_reg(REG_LAMBDA, 16'hffff);
                    default: write_reg(REG_LAMBDA, 16'($urandom));
                endcase
                case ($urandom_range(15))
                    0:       write_reg(REG_CLUSTERS, 16'd256);
                    1:       write_reg(REG_CLUSTERS, 16'd0);
                    2:       write_reg(REG_CLUSTERS, 16'($urandom));
                    default: write_reg(REG_CLUSTERS, 16'($urandom_range(1, 12)));
                endcase
            end
            docs++;
            case ($urandom_range(9))
                0: begin
                    logic [7:0] cl;
                    logic [6:0] el;
                    cl = 8'($urandom);
                    // with many clusters active stay on element 0 so loads stay few
                    el = (tracker.live_count() > WIDE_COUNT) ? 7'd0 : 7'($urandom);
                    load_needed(cl, el);
                    put(OP_DOC, cl, el, pick_value(), 1'($urandom));
                end
                1: put(OP_LOAD, 8'($urandom), 7'($urandom), pick_value(), 1'($urandom));
                default: begin
                    int len;
                    int mode;
                    len  = ($urandom_range(7) == 0) ? $urandom_range(7, 24)
                                                    : $urandom_range(1, 6);
                    if (tracker.live_count() > WIDE_COUNT) len = 1;
                    mode = $urandom_range(9);
                    mode = (mode < 6) ? 0 : (mode < 8) ? 2 : (mode == 8) ? 1 : 3;
                    document(8'($urandom), len, mode);
                end
            endcase
        end

        start <= 1'b0;
        wait_cycles = 0;
        while ((tracker.pending() != 0 || busy) && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);
        if (tracker.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, tracker.pending());
        if (tracker.fails == 0 && tracker.pending() == 0) begin
            $display("soar_spill_centroid_select: match");
        end else begin
            $display("soar_spill_centroid_select: mismatch");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #(8 * 30000000);
        $display("soar_spill_centroid_select: mismatch");
        $finish;
    end

endmodule
